// ===== rtl/core/lpht_pkg.sv =====
// Shared constants for the linear-probe hash table.
package lpht_pkg;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_FIND   = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_USED  = 2'd1;
  localparam logic [1:0] SLOT_TOMB  = 2'd2;

  localparam logic [63:0] HASH_SEED = 64'd5381;

endpackage

// ===== rtl/core/lpht_hash.sv =====
// Byte-serial djb2 hash unit: one byte per cycle.
module lpht_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] key,
  input  logic [3:0]  len,
  output logic        done,
  output logic [63:0] hash
);

  logic [3:0]  cnt;
  logic        busy;
  logic [63:0] sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        hash <= lpht_pkg::HASH_SEED;
        sh   <= key;
        cnt  <= len;
      end else if (busy) begin
        if (cnt == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          hash <= (hash << 5) + hash + {56'd0, sh[7:0]};
          sh   <= sh >> 8;
          cnt  <= cnt - 4'd1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/linear_probe_hash_table_top.sv =====
// Top level of the linear-probe hash table.
// One request at a time; no new request is taken until the previous result is
// taken. The key hash runs one byte per cycle through a multiply-by-33 adder.
// The probe then visits each slot with a registered read, then a compare,
// stopping at the key, an empty slot or after CAPACITY slots, and a done
// state follows that presents the result. Clear sweeps every slot state, one
// per cycle, and then presents its result. After reset a clearing pass over
// every slot runs before the first request is taken.
module linear_probe_hash_table_top #(
  parameter int CAPACITY      = 64,
  parameter int MAX_KEY_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [63:0] key_bytes,
  input  logic [3:0]  key_size,
  input  logic [31:0] value_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] value_out,
  output logic [6:0]  entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] LIMIT = CW'(CAPACITY - CAPACITY / 4);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH, S_READ, S_CHECK, S_DONE
  } state_t;

  state_t state;

  logic [1:0]  st_mem [CAPACITY];
  logic [63:0] key_mem [CAPACITY];
  logic [3:0]  len_mem [CAPACITY];
  logic [31:0] val_mem [CAPACITY];

  logic [1:0]  rd_st;
  logic [63:0] rd_key;
  logic [3:0]  rd_len;
  logic [31:0] rd_val;

  logic [1:0]    op;
  logic [63:0]   key;
  logic [3:0]    len;
  logic [31:0]   val;
  logic [AW-1:0] idx;
  logic [AW-1:0] tomb;
  logic          have_tomb;
  logic [CW-1:0] steps;
  logic [CW-1:0] occ;
  logic [CW-1:0] tombs;

  logic          hash_start;
  logic          hash_done;
  logic [63:0]   hash;

  logic [3:0]  len_sat;
  logic [63:0] key_mask;

  always_comb begin
    len_sat = (key_size > 4'(MAX_KEY_BYTES)) ? 4'(MAX_KEY_BYTES) : key_size;
    key_mask = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < len_sat) key_mask[i*8 +: 8] = 8'hff;
    end
  end

  assign in_ready   = (state == S_IDLE) && !out_valid;
  assign hash_start = in_valid && in_ready && (mode != lpht_pkg::MODE_CLEAR);

  lpht_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (key_bytes & key_mask),
    .len   (len_sat),
    .done  (hash_done),
    .hash  (hash)
  );

  always_ff @(posedge clk) begin
    rd_st  <= st_mem[idx];
    rd_key <= key_mem[idx];
    rd_len <= len_mem[idx];
    rd_val <= val_mem[idx];
  end

  logic          hit;
  logic [AW-1:0] ins_slot;
  assign hit      = (rd_st == lpht_pkg::SLOT_USED) && (rd_len == len) && (rd_key == key);
  assign ins_slot = have_tomb ? tomb : idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      op        <= lpht_pkg::MODE_INSERT;
      idx       <= '0;
      occ       <= '0;
      tombs     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          st_mem[idx] <= lpht_pkg::SLOT_EMPTY;
          idx <= idx + 1'b1;
          if (idx == AW'(CAPACITY - 1)) begin
            state <= S_IDLE;
            if (op == lpht_pkg::MODE_CLEAR) begin
              out_valid   <= 1'b1;
              status      <= lpht_pkg::ST_OK;
              value_out   <= '0;
              entry_count <= '0;
            end
          end
        end
        S_IDLE: begin
          op <= lpht_pkg::MODE_INSERT;
          if (in_valid && in_ready) begin
            op  <= mode;
            key <= key_bytes & key_mask;
            len <= len_sat;
            val <= value_in;
            have_tomb <= 1'b0;
            steps <= '0;
            idx   <= '0;
            if (mode == lpht_pkg::MODE_CLEAR) begin
              occ   <= '0;
              tombs <= '0;
              state <= S_CLEAR;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            idx   <= hash[AW-1:0];
            state <= S_READ;
          end
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          if (hit || rd_st == lpht_pkg::SLOT_EMPTY || steps == CW'(CAPACITY - 1)) begin
            state     <= S_DONE;
            value_out <= '0;
            status    <= lpht_pkg::ST_OK;
            case (op)
              lpht_pkg::MODE_INSERT: begin
                if (hit) begin
                  val_mem[idx] <= val;
                end else if (occ + tombs + 1'b1 >= LIMIT ||
                             (rd_st != lpht_pkg::SLOT_EMPTY && !have_tomb)) begin
                  status <= lpht_pkg::ST_FULL;
                end else begin
                  if (have_tomb) tombs <= tombs - 1'b1;
                  st_mem[ins_slot]  <= lpht_pkg::SLOT_USED;
                  key_mem[ins_slot] <= key;
                  len_mem[ins_slot] <= len;
                  val_mem[ins_slot] <= val;
                  occ <= occ + 1'b1;
                end
              end
              lpht_pkg::MODE_FIND: begin
                if (hit) value_out <= rd_val;
                else status <= lpht_pkg::ST_NOT_FOUND;
              end
              default: begin
                if (hit) begin
                  st_mem[idx] <= lpht_pkg::SLOT_TOMB;
                  occ   <= occ - 1'b1;
                  tombs <= tombs + 1'b1;
                end else begin
                  status <= lpht_pkg::ST_NOT_FOUND;
                end
              end
            endcase
          end else begin
            if (rd_st == lpht_pkg::SLOT_TOMB && !have_tomb) begin
              have_tomb <= 1'b1;
              tomb      <= idx;
            end
            idx   <= idx + 1'b1;
            steps <= steps + 1'b1;
            state <= S_READ;
          end
        end
        S_DONE: begin
          out_valid   <= 1'b1;
          entry_count <= 7'(occ);
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the linear-probe hash table top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 64;
  localparam int FILL_LIMIT = CAP - CAP / 4;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
    logic [6:0]  count;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  mode = lpht_pkg::MODE_FIND;
  logic [63:0] key_bytes = '0;
  logic [3:0]  key_size = '0;
  logic [31:0] value_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [31:0] value_out;
  logic [6:0]  entry_count;

  logic [1:0]  tbl_state [CAP];
  logic [63:0] tbl_key [CAP];
  logic [3:0]  tbl_len [CAP];
  logic [31:0] tbl_value [CAP];
  int          used_cnt;
  int          tomb_cnt;

  reply_t      expected_replies[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic [63:0] key_pool [16];
  logic [3:0]  len_pool [16];

  linear_probe_hash_table_top dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [5:0] home_slot(logic [63:0] k, int n);
    logic [63:0] h;
    h = lpht_pkg::HASH_SEED;
    for (int i = 0; i < n; i++) h = h * 64'd33 + {56'd0, k[8*i +: 8]};
    return h[5:0];
  endfunction

  function automatic reply_t table_apply(logic [1:0] m, logic [63:0] k, logic [3:0] l,
                                         logic [31:0] v);
    reply_t r;
    int n, idx, tomb, slot;
    bit found, have_tomb, done;
    r = '0;
    n = (l > 8) ? 8 : l;
    if (n < 8) k = k & ((64'd1 << (8 * n)) - 1);
    if (m == lpht_pkg::MODE_CLEAR) begin
      foreach (tbl_state[i]) tbl_state[i] = lpht_pkg::SLOT_EMPTY;
      used_cnt = 0;
      tomb_cnt = 0;
    end else begin
      idx = home_slot(k, n);
      tomb = CAP; have_tomb = 0; found = 0; done = 0; slot = CAP;
      for (int s = 0; s < CAP && !done; s++) begin
        if (tbl_state[idx] == lpht_pkg::SLOT_USED) begin
          if (tbl_len[idx] == n && tbl_key[idx] == k) begin
            found = 1; slot = idx; done = 1;
          end
        end else if (tbl_state[idx] == lpht_pkg::SLOT_TOMB) begin
          if (!have_tomb) begin
            tomb = idx; have_tomb = 1;
          end
        end else begin
          slot = have_tomb ? tomb : idx; done = 1;
        end
        idx = (idx + 1) % CAP;
      end
      if (!done) slot = tomb;
      case (m)
        lpht_pkg::MODE_INSERT: begin
          if (found) tbl_value[slot] = v;
          else if (used_cnt + tomb_cnt + 1 >= FILL_LIMIT || slot >= CAP)
            r.status = lpht_pkg::ST_FULL;
          else begin
            if (tbl_state[slot] == lpht_pkg::SLOT_TOMB) tomb_cnt--;
            tbl_state[slot] = lpht_pkg::SLOT_USED;
            tbl_key[slot] = k;
            tbl_len[slot] = 4'(n);
            tbl_value[slot] = v;
            used_cnt++;
          end
        end
        lpht_pkg::MODE_FIND: begin
          if (found) r.value = tbl_value[slot];
          else r.status = lpht_pkg::ST_NOT_FOUND;
        end
        default: begin
          if (found) begin
            tbl_state[slot] = lpht_pkg::SLOT_TOMB;
            used_cnt--;
            tomb_cnt++;
          end else r.status = lpht_pkg::ST_NOT_FOUND;
        end
      endcase
    end
    r.count = used_cnt[6:0];
    return r;
  endfunction

  task automatic send_request(logic [1:0] m, logic [63:0] k, logic [3:0] l, logic [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    key_bytes <= k;
    key_size <= l;
    value_in <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_replies.push_back(table_apply(m, k, l, v));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected reply status=%0d value=%h count=%0d", $time, status,
                   value_out, entry_count);
          errors++;
        end else begin
          reply_t e;
          e = expected_replies.pop_front();
          if (status !== e.status || value_out !== e.value || entry_count !== e.count) begin
            $display("%0t: mismatch expected status=%0d value=%h count=%0d", $time,
                     e.status, e.value, e.count);
            $display("%0t:          actual   status=%0d value=%h count=%0d", $time,
                     status, value_out, entry_count);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [63:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    send_request(lpht_pkg::MODE_FIND, 64'd0, 4'd0, 32'd0);
    send_request(lpht_pkg::MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 32'hFFFF_FFFF);
    send_request(lpht_pkg::MODE_FIND, 64'h0, 4'd0, 32'd0);
    send_request(lpht_pkg::MODE_INSERT, 64'h0000_0000_0000_0000, 4'd1, 32'h1);
    send_request(lpht_pkg::MODE_INSERT, 64'h0000_0000_0000_0000, 4'd2, 32'h2);
    send_request(lpht_pkg::MODE_FIND, 64'hAB00, 4'd1, 32'd0);
    send_request(lpht_pkg::MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'hA5A5_5A5A);
    send_request(lpht_pkg::MODE_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'd0);
    send_request(lpht_pkg::MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 32'h1234_5678);
    send_request(lpht_pkg::MODE_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'd0);
    send_request(lpht_pkg::MODE_REMOVE, 64'h0, 4'd1, 32'd0);
    send_request(lpht_pkg::MODE_REMOVE, 64'h0, 4'd1, 32'd0);
    send_request(lpht_pkg::MODE_FIND, 64'h0, 4'd1, 32'd0);
    send_request(lpht_pkg::MODE_INSERT, 64'h0, 4'd1, 32'h77);
    send_request(lpht_pkg::MODE_FIND, 64'h0, 4'd2, 32'd0);
    send_request(lpht_pkg::MODE_CLEAR, 64'h0, 4'd0, 32'd0);
    send_request(lpht_pkg::MODE_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'd0);
  endtask

  task automatic test_fill_limit();
    for (int i = 0; i < 50; i++)
      send_request(lpht_pkg::MODE_INSERT, rand_key(), 4'd8, $urandom);
    for (int i = 0; i < 4; i++) send_request(lpht_pkg::MODE_INSERT, 64'hFF, 4'd1, $urandom);
    send_request(lpht_pkg::MODE_CLEAR, 64'h0, 4'd0, 32'd0);
  endtask

  task automatic test_random(int count);
    logic [1:0] m;
    int p;
    for (int i = 0; i < 16; i++) begin
      key_pool[i] = rand_key();
      len_pool[i] = 4'($urandom_range(8));
    end
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(15);
      case ($urandom_range(99)) inside
        [0:39]:  m = lpht_pkg::MODE_INSERT;
        [40:69]: m = lpht_pkg::MODE_FIND;
        [70:97]: m = lpht_pkg::MODE_REMOVE;
        default: m = lpht_pkg::MODE_CLEAR;
      endcase
      if ($urandom_range(9) < 7)
        send_request(m, key_pool[p] |
                     ($urandom_range(1) ? rand_key() << (8 * len_pool[p]) : 64'd0),
                     len_pool[p], $urandom);
      else
        send_request(m, rand_key(), 4'($urandom_range(15)), $urandom);
    end
  endtask

  initial begin
    foreach (tbl_state[i]) tbl_state[i] = lpht_pkg::SLOT_EMPTY;
    used_cnt = 0;
    tomb_cnt = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_fill_limit();
    send_idle_pct = 9; recv_idle_pct = 69;
    test_random(330);
    drain();
    send_idle_pct = 69; recv_idle_pct = 9;
    test_random(330);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(340);
    drain();
    if (errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench failed");
    $finish;
  end
endmodule
